[hdl/pchg_pkg.sv]
// Shared types and constants of the point cloud height grid.
`default_nettype none

package pchg_pkg;

   // Grid geometry.
   localparam int GRID_COLS  = 256;
   localparam int GRID_ROWS  = 256;
   localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int COL_W      = $clog2(GRID_COLS);
   localparam int ROW_W      = $clog2(GRID_ROWS);

   // Field widths.
   localparam int COORD_W = 14;
   localparam int NORM_W  = 16;
   localparam int INDEX_W = 8;
   localparam int SIZE_W  = 10;
   localparam int COUNT_W = 16;
   localparam int SUM_W   = 32;

   localparam logic [COUNT_W-1:0]       TALLY_MAX  = '1;
   localparam logic signed [NORM_W-1:0] NORMAL_ONE = 16'sd16384;

   // Shared divider: one quotient bit per lane and cycle.
   localparam int DIV_LANES = 4;
   localparam int DIV_W     = SUM_W;
   localparam int DIVISOR_W = COUNT_W;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = COORD_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRID_MIN_X  = 3'd0,
      CSR_GRID_MAX_X  = 3'd1,
      CSR_GRID_MIN_Y  = 3'd2,
      CSR_GRID_MAX_Y  = 3'd3,
      CSR_CELL_SIZE   = 3'd4,
      CSR_HEIGHT_LOW  = 3'd5,
      CSR_HEIGHT_HIGH = 3'd6
   } csr_index_type;

   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_READ = 1'b1
   } op_type;

   localparam int REQ_FIELDS_W = 3 * COORD_W + 3 * NORM_W + 2 * INDEX_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = COORD_W + 3 * NORM_W + COUNT_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Request word; the last field declared sits in the lowest bits.
   typedef struct packed {
      logic [REQ_TDATA_W-REQ_FIELDS_W-1:0] pad;
      logic [INDEX_W-1:0]                  cell_row;
      logic [INDEX_W-1:0]                  cell_col;
      logic signed [NORM_W-1:0]            surf_nz;
      logic signed [NORM_W-1:0]            surf_ny;
      logic signed [NORM_W-1:0]            surf_nx;
      logic signed [COORD_W-1:0]           point_z;
      logic signed [COORD_W-1:0]           point_y;
      logic signed [COORD_W-1:0]           point_x;
   } req_word_type;

   // Response word; the last field declared sits in the lowest bits.
   typedef struct packed {
      logic [RSP_TDATA_W-RSP_FIELDS_W-1:0] pad;
      logic [COUNT_W-1:0]                  hit_count;
      logic signed [NORM_W-1:0]            mean_nz;
      logic signed [NORM_W-1:0]            mean_ny;
      logic signed [NORM_W-1:0]            mean_nx;
      logic signed [COORD_W-1:0]           mean_height;
   } rsp_word_type;

   // One grid cell as stored in memory.
   typedef struct packed {
      logic [COUNT_W-1:0] point_tally;
      logic [SUM_W-1:0]   nz_sum;
      logic [SUM_W-1:0]   ny_sum;
      logic [SUM_W-1:0]   nx_sum;
      logic [SUM_W-1:0]   height_sum;
   } cell_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

[hdl/point_cloud_height_grid.sv]
// Top level of the point cloud height grid: window check, binning, cell memory, readout.
`default_nettype none

// Points and read requests enter as words on the req_ stream; tuser selects add (0) or
// read-and-clear (1). One word is worked on at a time. After reset the block clears all
// GRID_COLS * GRID_ROWS (65536) cell memory entries before it takes a word;
// configuration writes are taken during that pass. A point outside the window is
// dropped; a binned point and a read of an occupied cell spend almost all their time
// in the shared divider, which produces one quotient bit per cycle (cell index on add,
// four rounded means on read). A read of an empty cell, or of one outside the grid,
// skips the divider. Each cell update is a read, modify and write of one memory entry
// with a registered read. A finished result sits in the output register while the next
// word is accepted.

module point_cloud_height_grid (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata, lowest bit up: point_x, point_y, point_z, surf_nx, surf_ny, surf_nz,
   // cell_col, cell_row, zero fill
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pchg_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                req_tuser,   // operation
   // rsp_tdata, lowest bit up: mean_height, mean_nx, mean_ny, mean_nz, hit_count,
   // zero fill
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pchg_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tuser,   // occupied
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pchg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pchg_pkg::CSR_DATA_W-1:0]     csr_data
);
   import pchg_pkg::*;

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_CHECK  = 8'b0000_0100,
      ST_BIN    = 8'b0000_1000,
      ST_FETCH  = 8'b0001_0000,
      ST_MODIFY = 8'b0010_0000,
      ST_MEAN   = 8'b0100_0000,
      ST_EMIT   = 8'b1000_0000
   } state_type;

   localparam logic signed [COORD_W-1:0] RESET_MIN_X  = -14'sd1000;
   localparam logic signed [COORD_W-1:0] RESET_MAX_X  = 14'sd3000;
   localparam logic signed [COORD_W-1:0] RESET_MIN_Y  = -14'sd2000;
   localparam logic signed [COORD_W-1:0] RESET_MAX_Y  = 14'sd2000;
   localparam logic [SIZE_W-1:0]         RESET_CS     = 10'd20;
   localparam logic signed [COORD_W-1:0] RESET_H_LOW  = -14'sd100;
   localparam logic signed [COORD_W-1:0] RESET_H_HIGH = 14'sd700;

   // An empty cell reads back as zero height and an upright normal.
   localparam rsp_word_type EMPTY_RESULT = '{pad:         '0,
                                             hit_count:   '0,
                                             mean_nz:     NORMAL_ONE,
                                             mean_ny:     '0,
                                             mean_nx:     '0,
                                             mean_height: '0};

   state_type                  state_ff;
   state_type                  state_in;

   logic signed [COORD_W-1:0]  min_x_ff;
   logic signed [COORD_W-1:0]  max_x_ff;
   logic signed [COORD_W-1:0]  min_y_ff;
   logic signed [COORD_W-1:0]  max_y_ff;
   logic [SIZE_W-1:0]          cell_size_ff;
   logic signed [COORD_W-1:0]  h_low_ff;
   logic signed [COORD_W-1:0]  h_high_ff;

   req_word_type               item_ff;
   op_type                     op_ff;
   logic [ADDR_W-1:0]          clear_addr_ff;
   logic [ADDR_W-1:0]          addr_ff;
   cell_type                   grid_mem_ff [CELL_COUNT];
   cell_type                   cell_rd_ff;
   logic [COUNT_W-1:0]         tally_ff;
   logic [DIV_LANES-1:0]       neg_ff;
   rsp_word_type               res_ff;
   logic                       res_occ_ff;
   logic                       rsp_tvalid_ff;
   rsp_word_type               rsp_tdata_ff;
   logic                       rsp_tuser_ff;

   logic                       req_accept;
   logic                       in_window;
   logic                       in_grid;
   logic [COORD_W:0]           off_x;
   logic [COORD_W:0]           off_y;
   logic [SIZE_W-1:0]          cs_eff;
   logic [COL_W-1:0]           bin_col;
   logic [ROW_W-1:0]           bin_row;
   logic [ADDR_W-1:0]          bin_addr;
   logic [ADDR_W-1:0]          read_addr;
   logic [SUM_W-1:0]           sums [DIV_LANES];
   logic [DIV_LANES-1:0]       sum_neg;
   logic [DIV_LANES-1:0][DIV_W-1:0] div_dividend;
   logic [DIVISOR_W-1:0]       div_divisor;
   logic [DIV_LANES-1:0][DIV_W-1:0] div_quotient;
   logic [DIV_W-1:0]           mean_val [DIV_LANES];
   div_status_type             div_status;
   logic                       div_start;
   logic                       emit_load;
   logic                       mem_we;
   logic [ADDR_W-1:0]          mem_waddr;
   cell_type                   mem_wdata;
   cell_type                   cell_upd;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff     <= RESET_MIN_X;
         max_x_ff     <= RESET_MAX_X;
         min_y_ff     <= RESET_MIN_Y;
         max_y_ff     <= RESET_MAX_Y;
         cell_size_ff <= RESET_CS;
         h_low_ff     <= RESET_H_LOW;
         h_high_ff    <= RESET_H_HIGH;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GRID_MIN_X:  min_x_ff     <= csr_data;
            CSR_GRID_MAX_X:  max_x_ff     <= csr_data;
            CSR_GRID_MIN_Y:  min_y_ff     <= csr_data;
            CSR_GRID_MAX_Y:  max_y_ff     <= csr_data;
            CSR_CELL_SIZE:   cell_size_ff <= csr_data[SIZE_W-1:0];
            CSR_HEIGHT_LOW:  h_low_ff     <= csr_data;
            CSR_HEIGHT_HIGH: h_high_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // Window test and cell offsets of an add word.
   assign in_window = item_ff.point_x >= min_x_ff && item_ff.point_x <= max_x_ff &&
                      item_ff.point_y >= min_y_ff && item_ff.point_y <= max_y_ff &&
                      item_ff.point_z >= h_low_ff && item_ff.point_z <= h_high_ff;
   assign off_x  = {item_ff.point_x[COORD_W-1], item_ff.point_x} -
                   {min_x_ff[COORD_W-1], min_x_ff};
   assign off_y  = {item_ff.point_y[COORD_W-1], item_ff.point_y} -
                   {min_y_ff[COORD_W-1], min_y_ff};
   assign cs_eff = (cell_size_ff == '0) ? SIZE_W'(1) : cell_size_ff;

   // A coordinate on the upper bound, or a quotient past the grid, lands in the last cell.
   always_comb begin
      if (item_ff.point_x == max_x_ff || div_quotient[0] > DIV_W'(GRID_COLS - 1)) begin
         bin_col = COL_W'(GRID_COLS - 1);
      end else begin
         bin_col = div_quotient[0][COL_W-1:0];
      end
      if (item_ff.point_y == max_y_ff || div_quotient[1] > DIV_W'(GRID_ROWS - 1)) begin
         bin_row = ROW_W'(GRID_ROWS - 1);
      end else begin
         bin_row = div_quotient[1][ROW_W-1:0];
      end
   end

   assign bin_addr  = ADDR_W'(bin_row) * ADDR_W'(GRID_COLS) + ADDR_W'(bin_col);
   assign in_grid   = 32'(item_ff.cell_col) < 32'(GRID_COLS) &&
                      32'(item_ff.cell_row) < 32'(GRID_ROWS);
   assign read_addr = ADDR_W'(ROW_W'(item_ff.cell_row)) * ADDR_W'(GRID_COLS) +
                      ADDR_W'(COL_W'(item_ff.cell_col));

   // Divider operands: cell offsets on add, magnitude plus half the count on read.
   assign sums[0] = cell_rd_ff.height_sum;
   assign sums[1] = cell_rd_ff.nx_sum;
   assign sums[2] = cell_rd_ff.ny_sum;
   assign sums[3] = cell_rd_ff.nz_sum;

   always_comb begin
      for (int l = 0; l < DIV_LANES; l++) begin
         sum_neg[l] = sums[l][SUM_W-1];
      end
      if (state_ff == ST_CHECK) begin
         div_dividend    = '0;
         div_dividend[0] = DIV_W'(off_x[COORD_W-1:0]);
         div_dividend[1] = DIV_W'(off_y[COORD_W-1:0]);
         div_divisor     = DIVISOR_W'(cs_eff);
      end else begin
         for (int l = 0; l < DIV_LANES; l++) begin
            div_dividend[l] = (sum_neg[l] ? (SUM_W'(0) - sums[l]) : sums[l]) +
                              DIV_W'(cell_rd_ff.point_tally[COUNT_W-1:1]);
         end
         div_divisor = cell_rd_ff.point_tally;
      end
   end

   assign div_start = (state_ff == ST_CHECK && op_ff == OP_ADD && in_window) ||
                      (state_ff == ST_MODIFY && op_ff == OP_READ &&
                       cell_rd_ff.point_tally != '0);

   pchg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .status   (div_status)
   );

   always_comb begin
      for (int l = 0; l < DIV_LANES; l++) begin
         mean_val[l] = neg_ff[l] ? (DIV_W'(0) - div_quotient[l]) : div_quotient[l];
      end
   end

   // Cell memory: clearing pass, then read, modify and write back of one entry per word.
   always_comb begin
      cell_upd             = cell_rd_ff;
      cell_upd.height_sum  = cell_rd_ff.height_sum + SUM_W'(item_ff.point_z);
      cell_upd.nx_sum      = cell_rd_ff.nx_sum + SUM_W'(item_ff.surf_nx);
      cell_upd.ny_sum      = cell_rd_ff.ny_sum + SUM_W'(item_ff.surf_ny);
      cell_upd.nz_sum      = cell_rd_ff.nz_sum + SUM_W'(item_ff.surf_nz);
      cell_upd.point_tally = cell_rd_ff.point_tally + 1'b1;
   end

   assign mem_we    = (state_ff == ST_CLEAR) ||
                      (state_ff == ST_MODIFY &&
                       (op_ff == OP_READ || cell_rd_ff.point_tally != TALLY_MAX));
   assign mem_waddr = (state_ff == ST_CLEAR) ? clear_addr_ff : addr_ff;
   assign mem_wdata = (state_ff == ST_CLEAR || op_ff == OP_READ) ? '0 : cell_upd;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem_ff[mem_waddr] <= mem_wdata;
      end
      cell_rd_ff <= grid_mem_ff[addr_ff];
   end

   // Sequencer.
   assign emit_load = (state_ff == ST_EMIT) && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clear_addr_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (op_ff == OP_ADD) begin
               state_in = in_window ? ST_BIN : ST_IDLE;
            end else begin
               state_in = in_grid ? ST_FETCH : ST_EMIT;
            end
         end
         ST_BIN: begin
            if (div_status.done) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            if (op_ff == OP_ADD) begin
               state_in = ST_IDLE;
            end else if (cell_rd_ff.point_tally == '0) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            if (div_status.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clear_addr_ff <= clear_addr_ff + 1'b1;
         end
         if (emit_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_word_type'(req_tdata);
         op_ff   <= op_type'(req_tuser);
      end
      if (state_ff == ST_CHECK && op_ff == OP_READ) begin
         addr_ff <= read_addr;
      end
      if (state_ff == ST_BIN && div_status.done) begin
         addr_ff <= bin_addr;
      end
      // The entry is cleared in this cycle, so keep what the means still need.
      if (state_ff == ST_MODIFY) begin
         tally_ff <= cell_rd_ff.point_tally;
         neg_ff   <= sum_neg;
      end
      if ((state_ff == ST_CHECK && op_ff == OP_READ && !in_grid) ||
          (state_ff == ST_MODIFY && op_ff == OP_READ && cell_rd_ff.point_tally == '0)) begin
         res_ff     <= EMPTY_RESULT;
         res_occ_ff <= 1'b0;
      end
      if (state_ff == ST_MEAN && div_status.done) begin
         res_ff     <= '{pad:         '0,
                         hit_count:   tally_ff,
                         mean_nz:     mean_val[3][NORM_W-1:0],
                         mean_ny:     mean_val[2][NORM_W-1:0],
                         mean_nx:     mean_val[1][NORM_W-1:0],
                         mean_height: mean_val[0][COORD_W-1:0]};
         res_occ_ff <= 1'b1;
      end
      if (emit_load) begin
         rsp_tdata_ff <= res_ff;
         rsp_tuser_ff <= res_occ_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while still running");

   a_emit_read_only: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> op_ff == OP_READ)
      else $error("result produced for an add word");

   a_occupied_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> rsp_tuser_ff == (rsp_tdata_ff.hit_count != '0))
      else $error("occupied flag disagrees with hit count");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && !rsp_tuser_ff |->
         rsp_tdata_ff.mean_nz == NORMAL_ONE && rsp_tdata_ff.mean_height == '0)
      else $error("empty cell result malformed");

endmodule

`default_nettype wire

[hdl/pchg_div.sv]
// Multi-lane restoring divider sharing one divisor, one quotient bit per cycle.
`default_nettype none

module pchg_div (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                start,
   input  logic [pchg_pkg::DIV_LANES-1:0][pchg_pkg::DIV_W-1:0] dividend,
   input  logic [pchg_pkg::DIVISOR_W-1:0]                      divisor,
   output logic [pchg_pkg::DIV_LANES-1:0][pchg_pkg::DIV_W-1:0] quotient,
   output pchg_pkg::div_status_type                            status
);
   import pchg_pkg::*;

   logic                                  busy_ff;
   logic                                  done_ff;
   logic [DIV_CNT_W-1:0]                  count_ff;
   logic [DIVISOR_W-1:0]                  divisor_ff;
   logic [DIV_LANES-1:0][DIVISOR_W-1:0]   rem_ff;
   logic [DIV_LANES-1:0][DIVISOR_W-1:0]   rem_in;
   logic [DIV_LANES-1:0][DIV_W-1:0]       quo_ff;
   logic [DIV_LANES-1:0][DIV_W-1:0]       quo_in;
   logic [DIV_LANES-1:0][DIVISOR_W:0]     shifted;
   logic [DIV_LANES-1:0][DIVISOR_W:0]     difference;
   logic [DIV_LANES-1:0]                  take;

   // The dividend shifts out of the top of quo_ff while quotient bits enter at the bottom.
   always_comb begin
      for (int l = 0; l < DIV_LANES; l++) begin
         shifted[l]    = {rem_ff[l], quo_ff[l][DIV_W-1]};
         difference[l] = shifted[l] - {1'b0, divisor_ff};
         take[l]       = shifted[l] >= {1'b0, divisor_ff};
         rem_in[l]     = take[l] ? difference[l][DIVISOR_W-1:0] : shifted[l][DIVISOR_W-1:0];
         quo_in[l]     = {quo_ff[l][DIV_W-2:0], take[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= DIV_CNT_W'(DIV_W - 1);
         end else if (busy_ff) begin
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         divisor_ff <= divisor;
         quo_ff     <= dividend;
         rem_ff     <= '0;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("divider done without a finished run");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      busy_ff && count_ff != '0 && !start |=> busy_ff && !done_ff)
      else $error("divider stopped before its last step");

endmodule

`default_nettype wire
